// ===== hdl/rmq_pkg.sv =====
// shared types and constants of the rotation matrix to quaternion core
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // derived widths
  localparam int NUM_W    = DATA_WIDTH + 1;
  localparam int RAD_W    = DATA_WIDTH + 3;
  localparam int SQN_W    = 2 * DATA_WIDTH;
  localparam int ROOT_W   = DATA_WIDTH;
  localparam int SQREM_W  = ROOT_W + 2;
  localparam int DVN_W    = NUM_W + FRAC_BITS;
  localparam int DIV_W    = ROOT_W + 1;
  localparam int DVREM_W  = DIV_W + 1;
  localparam int QUO_W    = DATA_WIDTH;
  localparam int HI_W     = DVN_W - QUO_W;
  localparam int STEPS    = 2;
  localparam int SQ_STAGES = ROOT_W / STEPS;
  localparam int DV_STAGES = QUO_W / STEPS;
  localparam int LANES    = 4;

  // lane codes
  localparam logic [1:0] LANE_W = 2'd0;
  localparam logic [1:0] LANE_X = 2'd1;
  localparam logic [1:0] LANE_Y = 2'd2;
  localparam logic [1:0] LANE_Z = 2'd3;

  localparam logic signed [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic                         bad_matrix;
  } out_req_t;

  // square root stage contents
  typedef struct packed {
    logic                        valid;
    logic [1:0]                  lead;
    logic                        bad;
    logic [LANES-1:0][NUM_W-1:0] num;
    logic [SQN_W-1:0]            n;
    logic [SQREM_W-1:0]          rem;
    logic [ROOT_W-1:0]           root;
  } sq_stage_t;

  // divider stage contents
  typedef struct packed {
    logic                          valid;
    logic [1:0]                    lead;
    logic                          bad;
    logic [LANES-1:0][NUM_W-1:0]   num;
    logic [ROOT_W-1:0]             root;
    logic [LANES-1:0][QUO_W-1:0]   low;
    logic [LANES-1:0][DVREM_W-1:0] rem;
    logic [LANES-1:0][QUO_W-1:0]   quo;
    logic [LANES-1:0]              ovf;
  } dv_stage_t;

endpackage

// ===== hdl/rotation_matrix_to_quaternion_core.sv =====
// rotation matrix to quaternion core: pipelined square root and dividers
// stages: 1 setup, 8 root, 1 divide setup, 8 divide and 1 output stage
// throughput: one request per cycle; a stalled output holds every stage
// reset: synchronous rst clears all stage valid bits, no clearing pass
module rotation_matrix_to_quaternion_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rmq_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rmq_pkg::out_req_t out_data
);

  localparam int DW = rmq_pkg::DATA_WIDTH;
  localparam int FB = rmq_pkg::FRAC_BITS;
  localparam int RW = rmq_pkg::RAD_W;
  localparam int NW = rmq_pkg::NUM_W;

  logic adv;
  rmq_pkg::sq_stage_t sq [rmq_pkg::SQ_STAGES+1];
  rmq_pkg::dv_stage_t dv [rmq_pkg::DV_STAGES+1];
  rmq_pkg::sq_stage_t sq_first;
  rmq_pkg::sq_stage_t sq_next [rmq_pkg::SQ_STAGES];
  rmq_pkg::dv_stage_t dv_first;
  rmq_pkg::dv_stage_t dv_next [rmq_pkg::DV_STAGES];
  rmq_pkg::out_req_t  res_next;

  // whole pipeline moves when the output can take a result
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // setup: branch choice, radicand and numerators per lane
  always_comb begin
    logic signed [RW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [RW-1:0] tr, rad;
    logic signed [RW-1:0] nw, nx, ny, nz;
    logic [1:0] lead;
    a00 = RW'(in_data.m00); a01 = RW'(in_data.m01); a02 = RW'(in_data.m02);
    a10 = RW'(in_data.m10); a11 = RW'(in_data.m11); a12 = RW'(in_data.m12);
    a20 = RW'(in_data.m20); a21 = RW'(in_data.m21); a22 = RW'(in_data.m22);
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      lead = rmq_pkg::LANE_W;
      rad  = tr + RW'(1 << FB);
      nw = '0; nx = a21 - a12; ny = a02 - a20; nz = a10 - a01;
    end else if (a22 > ((a11 > a00) ? a11 : a00)) begin
      lead = rmq_pkg::LANE_Z;
      rad  = a22 - a00 - a11 + RW'(1 << FB);
      nw = a10 - a01; nx = a02 + a20; ny = a12 + a21; nz = '0;
    end else if (a11 > a00) begin
      lead = rmq_pkg::LANE_Y;
      rad  = a11 - a22 - a00 + RW'(1 << FB);
      nw = a02 - a20; nx = a01 + a10; ny = '0; nz = a21 + a12;
    end else begin
      lead = rmq_pkg::LANE_X;
      rad  = a00 - a11 - a22 + RW'(1 << FB);
      nw = a21 - a12; nx = '0; ny = a10 + a01; nz = a20 + a02;
    end
    sq_first.valid = in_valid;
    sq_first.lead  = lead;
    sq_first.bad   = (rad <= 0);
    sq_first.num[rmq_pkg::LANE_W] = nw[NW-1:0];
    sq_first.num[rmq_pkg::LANE_X] = nx[NW-1:0];
    sq_first.num[rmq_pkg::LANE_Y] = ny[NW-1:0];
    sq_first.num[rmq_pkg::LANE_Z] = nz[NW-1:0];
    sq_first.n    = (rad <= 0) ? '0 : rmq_pkg::SQN_W'({rad[RW-3:0], {FB{1'b0}}});
    sq_first.rem  = '0;
    sq_first.root = '0;
  end

  // square root: two result bits per stage
  always_comb begin
    logic [rmq_pkg::SQREM_W+1:0] r;
    logic [rmq_pkg::SQREM_W+1:0] t;
    for (int s = 0; s < rmq_pkg::SQ_STAGES; s++) begin
      sq_next[s] = sq[s];
      for (int k = 0; k < rmq_pkg::STEPS; k++) begin
        r = {sq_next[s].rem, sq_next[s].n[rmq_pkg::SQN_W-1 -: 2]};
        t = (rmq_pkg::SQREM_W+2)'({sq_next[s].root, 2'b01});
        sq_next[s].n = {sq_next[s].n[rmq_pkg::SQN_W-3:0], 2'b00};
        if (r >= t) begin
          r = r - t;
          sq_next[s].root = {sq_next[s].root[rmq_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          sq_next[s].root = {sq_next[s].root[rmq_pkg::ROOT_W-2:0], 1'b0};
        end
        sq_next[s].rem = r[rmq_pkg::SQREM_W-1:0];
      end
    end
  end

  // divide setup: dividend = |num| * 2^frac + root, divisor = 2 * root
  always_comb begin
    logic signed [NW-1:0] nv;
    logic [NW-1:0] mag;
    logic [rmq_pkg::DVN_W-1:0] nn;
    logic [rmq_pkg::DIV_W-1:0] d;
    rmq_pkg::sq_stage_t src;
    src = sq[rmq_pkg::SQ_STAGES];
    d   = {src.root, 1'b0};
    dv_first.valid = src.valid;
    dv_first.lead  = src.lead;
    dv_first.bad   = src.bad;
    dv_first.num   = src.num;
    dv_first.root  = src.root;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      nv  = $signed(src.num[l]);
      mag = nv[NW-1] ? NW'(-nv) : NW'(nv);
      nn  = {mag, {FB{1'b0}}} + rmq_pkg::DVN_W'(src.root);
      dv_first.ovf[l] = (rmq_pkg::DIV_W'(nn[rmq_pkg::DVN_W-1 -: rmq_pkg::HI_W]) >= d);
      dv_first.rem[l] = rmq_pkg::DVREM_W'(nn[rmq_pkg::DVN_W-1 -: rmq_pkg::HI_W]);
      dv_first.low[l] = nn[rmq_pkg::QUO_W-1:0];
      dv_first.quo[l] = '0;
    end
  end

  // restoring division: two quotient bits per stage in each lane
  always_comb begin
    logic [rmq_pkg::DVREM_W-1:0] r;
    logic [rmq_pkg::DVREM_W-1:0] d;
    for (int s = 0; s < rmq_pkg::DV_STAGES; s++) begin
      dv_next[s] = dv[s];
      d = rmq_pkg::DVREM_W'({dv[s].root, 1'b0});
      for (int l = 0; l < rmq_pkg::LANES; l++) begin
        for (int k = 0; k < rmq_pkg::STEPS; k++) begin
          r = {dv_next[s].rem[l][rmq_pkg::DVREM_W-2:0], dv_next[s].low[l][rmq_pkg::QUO_W-1]};
          dv_next[s].low[l] = {dv_next[s].low[l][rmq_pkg::QUO_W-2:0], 1'b0};
          if (r >= d) begin
            r = r - d;
            dv_next[s].quo[l] = {dv_next[s].quo[l][rmq_pkg::QUO_W-2:0], 1'b1};
          end else begin
            dv_next[s].quo[l] = {dv_next[s].quo[l][rmq_pkg::QUO_W-2:0], 1'b0};
          end
          dv_next[s].rem[l] = r;
        end
      end
    end
  end

  // output: leading lane, zero numerator, saturation and sign
  always_comb begin
    logic signed [DW-1:0] val [rmq_pkg::LANES];
    logic [rmq_pkg::ROOT_W:0] lead_v;
    logic signed [NW-1:0] nv;
    logic [rmq_pkg::QUO_W-1:0] q;
    rmq_pkg::dv_stage_t src;
    src    = dv[rmq_pkg::DV_STAGES];
    lead_v = ((rmq_pkg::ROOT_W+1)'(src.root) + 1'b1) >> 1;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      nv = $signed(src.num[l]);
      q  = src.quo[l];
      if (2'(l) == src.lead) begin
        val[l] = (lead_v > (rmq_pkg::ROOT_W+1)'(rmq_pkg::Q_MAX)) ? rmq_pkg::Q_MAX
                                                                 : DW'(lead_v);
      end else if (nv == 0) begin
        val[l] = '0;
      end else if (src.bad || src.ovf[l]) begin
        val[l] = nv[NW-1] ? rmq_pkg::Q_MIN : rmq_pkg::Q_MAX;
      end else if (!nv[NW-1]) begin
        val[l] = (q > rmq_pkg::QUO_W'(rmq_pkg::Q_MAX)) ? rmq_pkg::Q_MAX : DW'(q);
      end else begin
        val[l] = (q > rmq_pkg::QUO_W'(rmq_pkg::Q_MIN)) ? rmq_pkg::Q_MIN : DW'(-q);
      end
    end
    res_next.quat_w     = val[rmq_pkg::LANE_W];
    res_next.quat_x     = val[rmq_pkg::LANE_X];
    res_next.quat_y     = val[rmq_pkg::LANE_Y];
    res_next.quat_z     = val[rmq_pkg::LANE_Z];
    res_next.bad_matrix = src.bad;
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= rmq_pkg::SQ_STAGES; s++) sq[s].valid <= 1'b0;
      for (int s = 0; s <= rmq_pkg::DV_STAGES; s++) dv[s].valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      sq[0] <= sq_first;
      for (int s = 0; s < rmq_pkg::SQ_STAGES; s++) sq[s+1] <= sq_next[s];
      dv[0] <= dv_first;
      for (int s = 0; s < rmq_pkg::DV_STAGES; s++) dv[s+1] <= dv_next[s];
      out_valid <= dv[rmq_pkg::DV_STAGES].valid;
      out_data  <= res_next;
    end
  end

endmodule
